[hw/rtl/mcma_pkg.sv]
package mcma_pkg;

    localparam int CHANNELS     = 7;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int CFG_W        = 7;
    localparam int WINDOW_RESET = 8;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS    = 8;

    localparam logic [CH_W-1:0] CH_ACCEL_X = CH_W'(0);
    localparam logic [CH_W-1:0] CH_ACCEL_Y = CH_W'(1);
    localparam logic [CH_W-1:0] CH_ACCEL_Z = CH_W'(2);
    localparam logic [CH_W-1:0] CH_TEMP    = CH_W'(3);
    localparam logic [CH_W-1:0] CH_GYRO_X  = CH_W'(4);
    localparam logic [CH_W-1:0] CH_GYRO_Y  = CH_W'(5);
    localparam logic [CH_W-1:0] CH_GYRO_Z  = CH_W'(6);
    localparam logic [CH_W-1:0] CH_LAST    = CH_GYRO_Z;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_accel_x;
        t_sample sample_accel_y;
        t_sample sample_accel_z;
        t_sample sample_temp;
        t_sample sample_gyro_x;
        t_sample sample_gyro_y;
        t_sample sample_gyro_z;
    } t_in_item;

    typedef struct packed {
        t_sample avg_accel_x;
        t_sample avg_accel_y;
        t_sample avg_accel_z;
        t_sample avg_temp;
        t_sample avg_gyro_x;
        t_sample avg_gyro_y;
        t_sample avg_gyro_z;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } t_state;

    // pick one channel's sample out of an input item
    function automatic t_sample in_sample(t_in_item item, logic [CH_W-1:0] ch);
        t_sample s;
        unique case (ch)
            CH_ACCEL_X: s = item.sample_accel_x;
            CH_ACCEL_Y: s = item.sample_accel_y;
            CH_ACCEL_Z: s = item.sample_accel_z;
            CH_TEMP:    s = item.sample_temp;
            CH_GYRO_X:  s = item.sample_gyro_x;
            CH_GYRO_Y:  s = item.sample_gyro_y;
            CH_GYRO_Z:  s = item.sample_gyro_z;
            default:    s = '0;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/mcma_ram.sv]
module mcma_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mcma_divider.sv]
module mcma_divider #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quot
);

    localparam int STEPS = mcma_pkg::DIV_STEPS;
    localparam int ITER  = (DVD_W + STEPS - 1) / STEPS;
    localparam int PAD_W = ITER * STEPS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PAD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;
    logic [DVD_W-1:0] mag;
    logic [PAD_W-1:0] step_q;
    logic [DVS_W-1:0] step_rem;

    assign mag = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);

    // restoring long division, STEPS bits per cycle; quotient shifts in at the bottom
    always_comb begin
        logic [DVS_W:0]   t;
        logic [PAD_W-1:0] q;
        logic [DVS_W-1:0] rem;
        q   = r_q;
        rem = r_rem;
        for (int k = 0; k < STEPS; k++) begin
            t = {rem, q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                t    = t - {1'b0, r_dvs};
                q[0] = 1'b1;
            end
            rem = t[DVS_W-1:0];
        end
        step_q   = q;
        step_rem = rem;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ITER);
            n_q    = PAD_W'(mag);
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = step_q;
            n_rem = step_rem;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(DVD_W'(r_q)) : $signed(DVD_W'(r_q));

endmodule

[hw/rtl/multichannel_moving_average_unit.sv]
// Boxcar moving average over seven inertial-sensor channels.
//
// Input channel: one transfer carries one signed sample per channel
// (accelerometer x/y/z, temperature, gyro x/y/z) in a packed struct.
// Output channel: one transfer per input item, the mean of the newest
// 'window' samples of each channel, truncated toward zero.
// Configuration: i_cfg_we with i_cfg_wdata sets the window (0 taken as 1,
// values above WINDOW_MAX clipped) and refills every channel's history with
// its newest sample. Write it only while the block is idle.
//
// Timing: channels are handled one after another; each passes through a
// history and sum read, an update that starts the divider, divider steps
// of eight quotient bits each and a store of the quotient. Items are taken
// one at a time, and the single divider is shared by all seven channels.
// Reset: history, window sums and the slot pointer read as zero, window is 8;
// no clearing pass runs, the block is ready in the first cycle after reset.
// Stall: o_in_ready is high only in the idle state. A result waits in the
// output register while the next item is taken and processed; the next
// result is then held back, with no new input, until the first transfers.
module multichannel_moving_average_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mcma_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mcma_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [mcma_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int SB      = mcma_pkg::SAMPLE_BITS;
    localparam int CHN     = mcma_pkg::CHANNELS;
    localparam int CH_W    = mcma_pkg::CH_W;
    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int WINW    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SB + $clog2(WINDOW_MAX) + 1;
    localparam int HADDR_W = CH_W + IDX_W;
    localparam int CMP_W   = (WINW > mcma_pkg::CFG_W) ? WINW : mcma_pkg::CFG_W;
    localparam int WIN_RST = (WINDOW_MAX < mcma_pkg::WINDOW_RESET) ?
                             WINDOW_MAX : mcma_pkg::WINDOW_RESET;

    mcma_pkg::t_state   r_state, n_state;
    mcma_pkg::t_in_item r_in;
    mcma_pkg::t_out_item r_out, n_out;
    mcma_pkg::t_sample  r_res    [CHN];
    mcma_pkg::t_sample  r_latest [CHN];
    mcma_pkg::t_sample  r_refill [CHN];

    logic [CH_W-1:0]  r_ch;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [WINW-1:0]  r_window, n_window;
    logic [WINW-1:0]  r_fill;
    logic             r_stale;
    logic             r_out_valid;

    logic in_ready, calc_en, res_en, out_load;
    logic out_free;

    logic [IDX_W-1:0]        old_idx;
    logic [SB-1:0]           hist_rd;
    logic [SUM_W-1:0]        sum_rd;
    mcma_pkg::t_sample       new_s, lat_s, old_s;
    logic signed [SUM_W-1:0] base, new_sum;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;

    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcma_pkg::ST_IDLE: if (i_in_valid) n_state = mcma_pkg::ST_READ;
            mcma_pkg::ST_READ: n_state = mcma_pkg::ST_CALC;
            mcma_pkg::ST_CALC: n_state = mcma_pkg::ST_DIV;
            mcma_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = (r_ch == mcma_pkg::CH_LAST) ? mcma_pkg::ST_DONE
                                                          : mcma_pkg::ST_READ;
                end
            end
            mcma_pkg::ST_DONE: if (out_free) n_state = mcma_pkg::ST_IDLE;
            default: n_state = mcma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        calc_en  = 1'b0;
        res_en   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            mcma_pkg::ST_IDLE: in_ready = 1'b1;
            mcma_pkg::ST_READ: ;
            mcma_pkg::ST_CALC: calc_en = 1'b1;
            mcma_pkg::ST_DIV:  res_en = div_done;
            mcma_pkg::ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    assign o_in_ready = in_ready;

    // advance the newest slot with wrap at WINDOW_MAX
    assign n_slot = (r_slot == IDX_W'(WINDOW_MAX - 1)) ? '0 : r_slot + IDX_W'(1);

    // slot of the sample that drops out of the window
    always_comb begin
        logic [WINW:0] s_ext;
        logic [WINW:0] w_ext;
        logic [WINW:0] d;
        s_ext = (WINW + 1)'(r_slot);
        w_ext = (WINW + 1)'(r_window);
        if (s_ext >= w_ext) begin
            d = s_ext - w_ext;
        end else begin
            d = s_ext + (WINW + 1)'(WINDOW_MAX) - w_ext;
        end
        old_idx = d[IDX_W-1:0];
    end

    // clamp the written window into 1..WINDOW_MAX
    always_comb begin
        logic [CMP_W-1:0] v;
        v = CMP_W'(i_cfg_wdata);
        if (v == '0) begin
            n_window = WINW'(1);
        end else if (v > CMP_W'(WINDOW_MAX)) begin
            n_window = WINW'(WINDOW_MAX);
        end else begin
            n_window = WINW'(v);
        end
    end

    // ---------------- storage ----------------
    mcma_ram #(
        .WIDTH  (SB),
        .DEPTH  (2 ** HADDR_W),
        .ADDR_W (HADDR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (calc_en),
        .i_waddr ({r_ch, r_slot}),
        .i_wdata (new_s),
        .i_raddr ({r_ch, old_idx}),
        .o_rdata (hist_rd)
    );

    mcma_ram #(
        .WIDTH  (SUM_W),
        .DEPTH  (CHN),
        .ADDR_W (CH_W)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (calc_en),
        .i_waddr (r_ch),
        .i_wdata (new_sum),
        .i_raddr (r_ch),
        .o_rdata (sum_rd)
    );

    // ---------------- running sum update ----------------
    // After reset or a refill every history entry counts as the channel's sample
    // held in r_refill, so the sum restarts from window * that sample. Entries
    // written since the refill are tracked by r_fill; older ones read as the
    // refill sample.
    assign new_s = mcma_pkg::in_sample(r_in, r_ch);
    assign lat_s = r_refill[r_ch];
    assign old_s = (r_window <= r_fill) ? $signed(hist_rd) : lat_s;

    always_comb begin
        logic signed [SUM_W-1:0] w_ext;
        logic signed [SUM_W-1:0] l_ext;
        w_ext = $signed(SUM_W'(r_window));
        l_ext = SUM_W'(lat_s);
        if (r_stale) begin
            base = w_ext * l_ext;
        end else begin
            base = $signed(sum_rd);
        end
        new_sum = base - SUM_W'(old_s) + SUM_W'(new_s);
    end

    mcma_divider #(
        .DVD_W (SUM_W),
        .DVS_W (WINW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (calc_en),
        .i_dividend (new_sum),
        .i_divisor  (r_window),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------- result assembly ----------------
    always_comb begin
        n_out.avg_accel_x = r_res[mcma_pkg::CH_ACCEL_X];
        n_out.avg_accel_y = r_res[mcma_pkg::CH_ACCEL_Y];
        n_out.avg_accel_z = r_res[mcma_pkg::CH_ACCEL_Z];
        n_out.avg_temp    = r_res[mcma_pkg::CH_TEMP];
        n_out.avg_gyro_x  = r_res[mcma_pkg::CH_GYRO_X];
        n_out.avg_gyro_y  = r_res[mcma_pkg::CH_GYRO_Y];
        n_out.avg_gyro_z  = r_res[mcma_pkg::CH_GYRO_Z];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcma_pkg::ST_IDLE;
            r_ch        <= '0;
            r_slot      <= '0;
            r_window    <= WINW'(WIN_RST);
            r_fill      <= '0;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHN; c++) begin
                r_latest[c] <= '0;
                r_refill[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_ready && i_in_valid) begin
                r_slot <= n_slot;
                r_ch   <= '0;
            end
            if (calc_en) begin
                r_latest[r_ch] <= new_s;
            end
            if (res_en && r_ch != mcma_pkg::CH_LAST) begin
                r_ch <= r_ch + CH_W'(1);
            end
            // hold the result until the receiver takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_stale     <= 1'b0;
                if (r_fill != WINW'(WINDOW_MAX)) begin
                    r_fill <= r_fill + WINW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // window write: drop the tracked history, capture each channel's
            // newest sample as the refill value and restart the sums
            if (i_cfg_we) begin
                r_window <= n_window;
                r_fill   <= '0;
                r_stale  <= 1'b1;
                for (int c = 0; c < CHN; c++) begin
                    r_refill[c] <= r_latest[c];
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (res_en) begin
            r_res[r_ch] <= div_quot[SB-1:0];
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
